[hw/rtl/idh_pkg.sv]
`default_nettype none
package idh_pkg;

  localparam int KEY_W   = 32;
  localparam int ID_W    = 10;
  localparam int ID_NUM  = 1 << ID_W;
  localparam int COUNT_W = 11;
  localparam int ARITY_W = 3;
  localparam int STAT_W  = 3;
  localparam logic [ARITY_W-1:0] MAX_ARITY = 3'd4;
  localparam logic [KEY_W-1:0]   KEY_SIGN  = {1'b1, {(KEY_W-1){1'b0}}};

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELMIN = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd2;
  localparam logic [STAT_W-1:0] ST_ABSENT  = 3'd3;
  localparam logic [STAT_W-1:0] ST_PRESENT = 3'd4;

  typedef struct packed {
    logic [1:0]        op;
    logic signed [KEY_W-1:0] key;
    logic [ID_W-1:0]   id;
  } idh_in_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] min_key;
    logic [ID_W-1:0]   min_id;
    logic [COUNT_W-1:0] count;
    logic              is_empty;
    logic [STAT_W-1:0] status;
  } idh_out_t;

  // key held biased (sign flipped) so an unsigned compare orders it
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } idh_ent_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MAPCHK, S_DEL_A, S_DEL_B, S_UP_PAR, S_UP_CMP,
    S_DN_START, S_DN_CMP, S_DN_DEC, S_PLACE, S_ROOT, S_OUT
  } idh_state_t;

endpackage
`default_nettype wire

[hw/rtl/idh_ram.sv]
`default_nettype none
module idh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/idh_parent.sv]
`default_nettype none
module idh_parent
  import idh_pkg::*;
#(
  parameter int SW = 10
) (
  input  wire logic [SW-1:0]      slot,
  input  wire logic [ARITY_W-1:0] arity,
  output logic      [SW-1:0]      parent
);

  // divide by three as multiply by ceil(2^(SW+1)/3), exact below 2^SW
  localparam int unsigned RECIP = ((2 ** (SW + 1)) + 2) / 3;

  logic [SW-1:0]     x;
  logic [SW:0]       recip;
  logic [2*SW+1:0]   prod;

  assign x     = slot - SW'(1);
  assign recip = (SW+1)'(RECIP);
  assign prod  = {{(SW+2){1'b0}}, x} * {{(SW+1){1'b0}}, recip};

  always_comb begin
    case (arity)
      3'd3:    parent = prod[2*SW:SW+1];
      3'd4:    parent = x >> 2;
      default: parent = x >> 1;
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/indexed_dary_min_heap_unit.sv]
// channel | ports                        | role
// in      | in_valid, in_ready, in_data  | one operation word (insert, delete-min, update)
// out     | out_valid, out_ready, out_data | root, count and status after the operation
// cfg     | cfg_we, cfg_wdata            | arity register, written at once
//
// Steps: a rejected or unused operation passes map check, root read and output; an insert
// or delete adds its steps: sift-up reads and compares the parent a level, sift-down
// reads the children of a level one by one, bounded by the single read port of the slot RAM.
// Reset: a sweep marks all 1024 ids absent; no word is accepted meanwhile.
// Stalls: the result waits in an output register; the next word is accepted meanwhile,
// and its own result is held back until that register frees.
`default_nettype none
module indexed_dary_min_heap_unit
  import idh_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire idh_in_t       in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output idh_out_t           out_data,
  input  wire logic          cfg_we,
  input  wire logic [ARITY_W-1:0] cfg_wdata
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int FW = SW + 3;
  localparam int EW = $bits(idh_ent_t);

  idh_state_t state_r, state_nxt;
  logic [1:0]        op_r, op_nxt;
  idh_ent_t          mv_r, mv_nxt, best_r, best_nxt;
  logic [SW-1:0]     cur_r, cur_nxt, par_r, par_nxt, c_r, c_nxt;
  logic [SW-1:0]     last_r, last_nxt, bidx_r, bidx_nxt;
  logic              moved_r, moved_nxt, nobest_r, nobest_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [ID_W-1:0]   clr_r, clr_nxt;
  logic [ARITY_W-1:0] arity_r;
  logic [ARITY_W-1:0] d;
  idh_out_t          out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  // slot RAM and id map ports
  logic          slot_we, slot_re;
  logic [SW-1:0] slot_wa, slot_ra;
  idh_ent_t      slot_wd, slot_rd;
  logic          map_we, map_re;
  logic [ID_W-1:0] map_wa, map_ra;
  logic [SW:0]   map_wd, map_rd;

  logic [SW-1:0] parent;
  logic [FW-1:0] first, lastc, lim;
  logic          better, in_fire;

  idh_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_slot (
    .clk, .we(slot_we), .waddr(slot_wa), .wdata(slot_wd),
    .re(slot_re), .raddr(slot_ra), .rdata(slot_rd)
  );

  // id map entry: valid in the top bit, slot below
  idh_ram #(.WIDTH(SW + 1), .DEPTH(ID_NUM)) u_map (
    .clk, .we(map_we), .waddr(map_wa), .wdata(map_wd),
    .re(map_re), .raddr(map_ra), .rdata(map_rd)
  );

  idh_parent #(.SW(SW)) u_parent (.slot(cur_r), .arity(d), .parent(parent));

  // clamp arity into its legal range
  always_comb begin
    if (arity_r < 3'd2) begin
      d = 3'd2;
    end else if (arity_r > MAX_ARITY) begin
      d = MAX_ARITY;
    end else begin
      d = arity_r;
    end
  end

  // first and last child of the current slot, and the last held slot
  always_comb begin
    case (d)
      3'd3:    first = (FW'(cur_r) << 1) + FW'(cur_r) + FW'(1);
      3'd4:    first = (FW'(cur_r) << 2) + FW'(1);
      default: first = (FW'(cur_r) << 1) + FW'(1);
    endcase
    lastc = first + FW'(d) - FW'(1);
    lim   = FW'(cnt_r) - FW'(1);
  end

  assign better = (slot_rd.key < best_r.key) ||
                  ((slot_rd.key == best_r.key) && (slot_rd.id < best_r.id));
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arity_r <= 3'd2;
    end else if (cfg_we) begin
      arity_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    mv_r     <= mv_nxt;
    best_r   <= best_nxt;
    cur_r    <= cur_nxt;
    par_r    <= par_nxt;
    c_r      <= c_nxt;
    last_r   <= last_nxt;
    bidx_r   <= bidx_nxt;
    moved_r  <= moved_nxt;
    nobest_r <= nobest_nxt;
    status_r <= status_nxt;
    out_r    <= out_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    mv_nxt     = mv_r;
    best_nxt   = best_r;
    cur_nxt    = cur_r;
    par_nxt    = par_r;
    c_nxt      = c_r;
    last_nxt   = last_r;
    bidx_nxt   = bidx_r;
    moved_nxt  = moved_r;
    nobest_nxt = nobest_r;
    status_nxt = status_r;
    cnt_nxt    = cnt_r;
    clr_nxt    = clr_r;
    out_nxt    = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    slot_we = 1'b0;
    slot_wa = cur_r;
    slot_wd = mv_r;
    slot_re = 1'b0;
    slot_ra = '0;
    map_we  = 1'b0;
    map_wa  = mv_r.id;
    map_wd  = {1'b1, cur_r};
    map_re  = 1'b0;
    map_ra  = in_data.id;

    unique case (state_r)
      S_CLEAR: begin
        // mark every id absent, one a cycle
        map_we  = 1'b1;
        map_wa  = clr_r;
        map_wd  = '0;
        clr_nxt = clr_r + ID_W'(1);
        if (clr_r == {ID_W{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          map_re     = 1'b1;
          op_nxt     = in_data.op;
          mv_nxt.key = $unsigned(in_data.key) ^ KEY_SIGN;
          mv_nxt.id  = in_data.id;
          status_nxt = ST_OK;
          moved_nxt  = 1'b0;
          state_nxt  = S_MAPCHK;
        end
      end
      S_MAPCHK: begin
        case (op_r)
          OP_INSERT: begin
            if (map_rd[SW]) begin
              status_nxt = ST_PRESENT;
              state_nxt  = S_ROOT;
            end else if (cnt_r >= CW'(CAPACITY)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_ROOT;
            end else begin
              cur_nxt   = SW'(cnt_r);
              cnt_nxt   = cnt_r + CW'(1);
              state_nxt = S_UP_PAR;
            end
          end
          OP_DELMIN: begin
            if (cnt_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_ROOT;
            end else begin
              slot_re   = 1'b1;
              slot_ra   = '0;
              state_nxt = S_DEL_A;
            end
          end
          OP_UPDATE: begin
            if (!map_rd[SW] || (CW'(map_rd[SW-1:0]) >= cnt_r)) begin
              status_nxt = ST_ABSENT;
              state_nxt  = S_ROOT;
            end else begin
              cur_nxt   = map_rd[SW-1:0];
              state_nxt = S_UP_PAR;
            end
          end
          default: state_nxt = S_ROOT;
        endcase
      end
      S_DEL_A: begin
        // drop the root's id, fetch the last entry to refill the root
        map_we    = 1'b1;
        map_wa    = slot_rd.id;
        map_wd    = '0;
        slot_re   = 1'b1;
        slot_ra   = SW'(cnt_r - CW'(1));
        state_nxt = S_DEL_B;
      end
      S_DEL_B: begin
        mv_nxt  = slot_rd;
        cnt_nxt = cnt_r - CW'(1);
        cur_nxt = '0;
        if (cnt_r == CW'(1)) begin
          state_nxt = S_ROOT;
        end else begin
          state_nxt = S_DN_START;
        end
      end
      S_UP_PAR: begin
        if (cur_r == '0) begin
          state_nxt = (op_r == OP_UPDATE && !moved_r) ? S_DN_START : S_PLACE;
        end else begin
          par_nxt   = parent;
          slot_re   = 1'b1;
          slot_ra   = parent;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (mv_r.key < slot_rd.key) begin
          // pull the parent down into the hole
          slot_we   = 1'b1;
          slot_wd   = slot_rd;
          map_we    = 1'b1;
          map_wa    = slot_rd.id;
          cur_nxt   = par_r;
          moved_nxt = 1'b1;
          state_nxt = S_UP_PAR;
        end else begin
          state_nxt = (op_r == OP_UPDATE && !moved_r) ? S_DN_START : S_PLACE;
        end
      end
      S_DN_START: begin
        if (first > lim) begin
          state_nxt = S_PLACE;
        end else begin
          last_nxt   = (lastc > lim) ? lim[SW-1:0] : lastc[SW-1:0];
          c_nxt      = first[SW-1:0];
          slot_re    = 1'b1;
          slot_ra    = first[SW-1:0];
          nobest_nxt = 1'b1;
          state_nxt  = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (nobest_r || better) begin
          best_nxt = slot_rd;
          bidx_nxt = c_r;
        end
        nobest_nxt = 1'b0;
        if (c_r == last_r) begin
          state_nxt = S_DN_DEC;
        end else begin
          c_nxt   = c_r + SW'(1);
          slot_re = 1'b1;
          slot_ra = c_r + SW'(1);
        end
      end
      S_DN_DEC: begin
        if (best_r.key < mv_r.key) begin
          // lift the best child into the hole
          slot_we   = 1'b1;
          slot_wd   = best_r;
          map_we    = 1'b1;
          map_wa    = best_r.id;
          cur_nxt   = bidx_r;
          state_nxt = S_DN_START;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        slot_we   = 1'b1;
        map_we    = 1'b1;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        slot_re   = 1'b1;
        slot_ra   = '0;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_nxt.count    = COUNT_W'(cnt_r);
          out_nxt.status   = status_r;
          out_nxt.is_empty = (cnt_r == '0);
          if (cnt_r == '0) begin
            out_nxt.min_key = '0;
            out_nxt.min_id  = '0;
          end else begin
            out_nxt.min_key = $signed(slot_rd.key ^ KEY_SIGN);
            out_nxt.min_id  = slot_rd.id;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("word accepted while previous one in progress");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid_r)
    else $error("result raised during map sweep");

  a_sift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DN_START) |-> (CW'(cur_r) < cnt_r))
    else $error("sift-down slot outside held entries");

endmodule
`default_nettype wire
